/* design/assert_macros.svh */
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define PLI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PLI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define PLI_ASSERT(label, clk, rstn, prop, msg)
`define PLI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`endif

`endif

/* design/pli_pkg.sv */
package pli_pkg;

    localparam int OP_W    = 2;
    localparam int FIELD_W = 6;
    localparam int VALUE_W = 32;

    // input tdata layout
    localparam int IN_POS_LSB   = 0;
    localparam int IN_VAL_LSB   = IN_POS_LSB + FIELD_W;
    localparam int IN_CNT_LSB   = IN_VAL_LSB + VALUE_W;
    localparam int IN_TDATA_W   = 48;

    // output tdata layout
    localparam int OUT_OK_LSB   = 0;
    localparam int OUT_REM_LSB  = OUT_OK_LSB + 1;
    localparam int OUT_EL_LSB   = OUT_REM_LSB + FIELD_W;
    localparam int OUT_LEN_LSB  = OUT_EL_LSB + VALUE_W;
    localparam int OUT_USED_W   = OUT_LEN_LSB + FIELD_W;
    localparam int OUT_TDATA_W  = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 2'd0,
        OP_DELETE     = 2'd1,
        OP_DELETE_RUN = 2'd2,
        OP_READ_OUT   = 2'd3
    } pli_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SHIFT,
        ST_INS_VAL,
        ST_DEL_SHIFT,
        ST_RD_ISSUE,
        ST_RD_OUT,
        ST_RESP
    } pli_state_t;

endpackage

/* design/positional_list_insert_delete.sv */
// channel   direction  handshake         payload
// s_        in         tvalid / tready   tuser: operation; tdata: position, value, count
// m_        out        tvalid / tready   tuser: has_element; tdata: ok, removed, element,
//                                        list_length; tlast: is_last
//
// one item at a time, list entries in a single-port-write, one-read ram, length in a register
// insert: entries from the position to the tail move up one place, then the value is written
// delete / delete run: entries after the removed ones move down, one ram move per cycle
// read out: one element per cycle from the ram read port while the output does not stall
// synchronous active-low reset empties the list; entries are not cleared
// a result held in the output register does not block acceptance; m_tready low holds the fsm
`include "assert_macros.svh"

module positional_list_insert_delete import pli_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // position[5:0], value[37:6], count[43:38]
    input  logic [OP_W-1:0]        s_tuser,   // operation[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // ok[0], removed[6:1], element[38:7],
                                              // list_length[44:39]
    output logic                   m_tuser,   // has_element
    output logic                   m_tlast
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;

    pli_state_t state_reg, state_next;

    logic [CW-1:0]      len_reg, len_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      lim_reg, lim_next;
    logic [AW-1:0]      n_reg, n_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic               ok_reg, ok_next;
    logic [FIELD_W-1:0] removed_reg, removed_next;
    logic               wr_pend_reg, wr_pend_next;
    logic [AW-1:0]      wr_addr_reg, wr_addr_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_ok_reg;
    logic [FIELD_W-1:0] m_removed_reg;
    logic               m_has_el_reg;
    logic [VALUE_W-1:0] m_element_reg;
    logic               m_last_reg;
    logic [FIELD_W-1:0] m_len_reg;

    // input unpacking
    pli_op_t            op_in;
    logic [FIELD_W-1:0] pos_in;
    logic [VALUE_W-1:0] val_in;
    logic [FIELD_W-1:0] cnt_in;
    logic               accept;

    // request decode
    logic [EW-1:0] pos_e, req_e, len_e, idx_e, avail_e, run_n, del_n, src_e;
    logic          ins_ok, del_pos_ok, del_ok, shift_ins, shift_del;

    // control
    logic          out_free, out_load, at_lim, rd_busy;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [VALUE_W-1:0] mem_wdata, mem_rdata;

    assign op_in  = pli_op_t'(s_tuser);
    assign pos_in = s_tdata[IN_POS_LSB +: FIELD_W];
    assign val_in = s_tdata[IN_VAL_LSB +: VALUE_W];
    assign cnt_in = s_tdata[IN_CNT_LSB +: FIELD_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign at_lim   = (addr_reg == lim_reg);
    assign rd_busy  = (state_reg == ST_RD_ISSUE) || (state_reg == ST_RD_OUT);

    always_comb begin
        pos_e      = EW'(pos_in);
        req_e      = EW'(cnt_in);
        len_e      = EW'(len_reg);
        idx_e      = pos_e - EW'(1);
        ins_ok     = (len_e < EW'(DEPTH)) && (pos_e != '0) && (pos_e <= len_e + EW'(1));
        del_pos_ok = (pos_e != '0) && (pos_e <= len_e);
        avail_e    = len_e - pos_e + EW'(1);
        run_n      = del_pos_ok ? ((req_e < avail_e) ? req_e : avail_e) : '0;
        if (op_in == OP_DELETE) begin
            del_n  = del_pos_ok ? EW'(1) : '0;
            del_ok = del_pos_ok;
        end else begin
            del_n  = run_n;
            del_ok = (run_n == req_e);
        end
        src_e     = idx_e + del_n;
        shift_ins = ins_ok && (len_e > idx_e);
        shift_del = (del_n != '0) && (src_e < len_e);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (op_in)
                        OP_INSERT: begin
                            if (!ins_ok) begin
                                state_next = ST_RESP;
                            end else if (shift_ins) begin
                                state_next = ST_INS_SHIFT;
                            end else begin
                                state_next = ST_INS_VAL;
                            end
                        end
                        OP_DELETE, OP_DELETE_RUN: begin
                            state_next = shift_del ? ST_DEL_SHIFT : ST_RESP;
                        end
                        OP_READ_OUT: begin
                            state_next = (len_reg == '0) ? ST_RESP : ST_RD_ISSUE;
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_INS_SHIFT: begin
                if (at_lim) state_next = ST_INS_VAL;
            end
            ST_INS_VAL: begin
                if (!wr_pend_reg) state_next = ST_RESP;
            end
            ST_DEL_SHIFT: begin
                if (at_lim) state_next = ST_RESP;
            end
            ST_RD_ISSUE: state_next = ST_RD_OUT;
            ST_RD_OUT: begin
                if (out_free && at_lim) state_next = ST_IDLE;
            end
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory and result-register control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = addr_reg;
        out_load  = 1'b0;
        case (state_reg)
            ST_INS_SHIFT, ST_DEL_SHIFT, ST_RD_ISSUE: mem_re = 1'b1;
            ST_RD_OUT: begin
                out_load  = out_free;
                mem_re    = out_free && !at_lim;
                mem_raddr = addr_reg + AW'(1);
            end
            ST_RESP: out_load = out_free;
            default: ;
        endcase
        // a pending shift write goes first, the inserted value after it
        mem_we    = wr_pend_reg || (state_reg == ST_INS_VAL);
        mem_waddr = wr_pend_reg ? wr_addr_reg : lim_reg;
        mem_wdata = wr_pend_reg ? mem_rdata : val_reg;
    end

    // datapath
    always_comb begin
        len_next     = len_reg;
        addr_next    = addr_reg;
        lim_next     = lim_reg;
        n_next       = n_reg;
        val_next     = val_reg;
        ok_next      = ok_reg;
        removed_next = removed_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    val_next = val_in;
                    case (op_in)
                        OP_INSERT: begin
                            addr_next    = AW'(len_e - EW'(1));
                            lim_next     = AW'(idx_e);
                            ok_next      = ins_ok;
                            removed_next = '0;
                            if (ins_ok) len_next = len_reg + CW'(1);
                        end
                        OP_DELETE, OP_DELETE_RUN: begin
                            addr_next    = AW'(src_e);
                            lim_next     = AW'(len_e - EW'(1));
                            n_next       = AW'(del_n);
                            ok_next      = del_ok;
                            removed_next = FIELD_W'(del_n);
                            len_next     = len_reg - CW'(del_n);
                        end
                        default: begin
                            addr_next    = '0;
                            lim_next     = AW'(len_e - EW'(1));
                            ok_next      = 1'b1;
                            removed_next = '0;
                        end
                    endcase
                end
            end
            ST_INS_SHIFT: begin
                wr_pend_next = 1'b1;
                wr_addr_next = addr_reg + AW'(1);
                addr_next    = addr_reg - AW'(1);
            end
            ST_DEL_SHIFT: begin
                wr_pend_next = 1'b1;
                wr_addr_next = addr_reg - n_reg;
                addr_next    = addr_reg + AW'(1);
            end
            ST_RD_OUT: begin
                if (out_free && !at_lim) addr_next = addr_reg + AW'(1);
            end
            default: ;
        endcase
        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg    <= addr_next;
        lim_reg     <= lim_next;
        n_reg       <= n_next;
        val_reg     <= val_next;
        ok_reg      <= ok_next;
        removed_reg <= removed_next;
        wr_addr_reg <= wr_addr_next;
        if (out_load) begin
            if (state_reg == ST_RD_OUT) begin
                m_ok_reg      <= 1'b1;
                m_removed_reg <= '0;
                m_has_el_reg  <= 1'b1;
                m_element_reg <= mem_rdata;
                m_last_reg    <= at_lim;
            end else begin
                m_ok_reg      <= ok_reg;
                m_removed_reg <= removed_reg;
                m_has_el_reg  <= 1'b0;
                m_element_reg <= '0;
                m_last_reg    <= 1'b1;
            end
            m_len_reg <= FIELD_W'(len_reg);
        end
    end

    pli_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (VALUE_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_has_el_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, m_len_reg, m_element_reg,
                       m_removed_reg, m_ok_reg};

    `PLI_ASSERT(a_len_range, aclk, aresetn, len_reg <= CW'(DEPTH), "list length above depth")
    `PLI_ASSERT_IMPL(a_idle_no_pend, aclk, aresetn, s_tready, !wr_pend_reg, "write left at idle")
    `PLI_ASSERT_IMPL(a_rd_no_write, aclk, aresetn, rd_busy, !mem_we, "ram write during read out")

endmodule

/* design/pli_ram.sv */
module pli_ram #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* tb/sv/positional_list_insert_delete_tb.sv */
module positional_list_insert_delete_tb;
    import pli_pkg::*;

    localparam int DEPTH = 32;

    typedef struct {
        pli_op_t           op;
        logic [FIELD_W-1:0] pos;
        logic [VALUE_W-1:0] value;
        logic [FIELD_W-1:0] count;
        bit                hold;   // wait for every result before sending
    } list_cmd_t;

    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] removed;
        logic               has_el;
        logic [VALUE_W-1:0] element;
        logic               last;
        logic [FIELD_W-1:0] len;
    } list_result_t;

    logic                   aclk = 0;
    logic                   aresetn = 0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    positional_list_insert_delete #(.DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #2 aclk = ~aclk;

    list_cmd_t    cmd_queue[$];
    list_result_t expected_results[$];
    list_cmd_t    cur_cmd;

    // list model
    logic [VALUE_W-1:0] list_mem [DEPTH];
    int                 list_len = 0;
    int                 peak_len = 0;

    int  plan_len = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  n_ins = 0, n_del = 0, n_run = 0, n_rd = 0;
    int  send_gap = 0, recv_gap = 0;
    bit  send_calm = 0, recv_calm = 0;
    bit  s_taken = 0;

    function automatic int pick_gap(inout bit calm);
        int r;
        if ($urandom_range(0, 15) == 0)
            calm = !calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // length the list will have after c, used to aim positions while planning
    function automatic int len_after(list_cmd_t c, int len);
        int want, avail, p;
        p = int'(c.pos);
        case (c.op)
            OP_INSERT: return (len < DEPTH && p >= 1 && p <= len + 1) ? len + 1 : len;
            OP_DELETE, OP_DELETE_RUN: begin
                want = (c.op == OP_DELETE) ? 1 : int'(c.count);
                if (p < 1 || p > len)
                    return len;
                avail = len - p + 1;
                return len - (want < avail ? want : avail);
            end
            default: return len;
        endcase
    endfunction

    task automatic add_cmd(pli_op_t op, int pos, logic [VALUE_W-1:0] value, int count,
                           bit hold = 0);
        list_cmd_t c;
        c.op = op;
        c.pos = pos[FIELD_W-1:0];
        c.value = value;
        c.count = count[FIELD_W-1:0];
        c.hold = hold;
        plan_len = len_after(c, plan_len);
        cmd_queue.push_back(c);
    endtask

    // applies one accepted item to the list model and queues its results
    task automatic update_list(list_cmd_t c);
        list_result_t r;
        int p, want, n, avail;
        r = '0;
        r.last = 1;
        p = int'(c.pos);
        case (c.op)
            OP_INSERT: begin
                n_ins++;
                if (list_len < DEPTH && p >= 1 && p <= list_len + 1) begin
                    for (int j = list_len; j > p - 1; j--)
                        list_mem[j] = list_mem[j-1];
                    list_mem[p-1] = c.value;
                    list_len++;
                    r.ok = 1;
                end
                r.len = FIELD_W'(list_len);
                expected_results.push_back(r);
            end
            OP_DELETE, OP_DELETE_RUN: begin
                // a single delete behaves as a run of one
                if (c.op == OP_DELETE) n_del++; else n_run++;
                want = (c.op == OP_DELETE) ? 1 : int'(c.count);
                n = 0;
                if (p >= 1 && p <= list_len) begin
                    avail = list_len - p + 1;
                    n = want < avail ? want : avail;
                    for (int j = p - 1; j + n < list_len; j++)
                        list_mem[j] = list_mem[j+n];
                    list_len -= n;
                end
                r.ok = (n == want);
                r.removed = FIELD_W'(n);
                r.len = FIELD_W'(list_len);
                expected_results.push_back(r);
            end
            default: begin
                n_rd++;
                r.ok = 1;
                r.len = FIELD_W'(list_len);
                if (list_len == 0) begin
                    expected_results.push_back(r);
                end else begin
                    for (int j = 0; j < list_len; j++) begin
                        r.has_el = 1;
                        r.element = list_mem[j];
                        r.last = (j == list_len - 1);
                        expected_results.push_back(r);
                    end
                end
            end
        endcase
        if (list_len > peak_len)
            peak_len = list_len;
    endtask

    task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // driver
    always @(negedge aclk) begin : drive_proc
        list_cmd_t nxt;
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (send_gap > 0) begin
                s_tvalid <= 0;
                send_gap <= send_gap - 1;
            end else if (cmd_queue.size() > 0 &&
                         !(cmd_queue[0].hold && expected_results.size() != 0)) begin
                nxt = cmd_queue.pop_front();
                cur_cmd <= nxt;
                s_tvalid <= 1;
                s_tuser <= nxt.op;
                s_tdata <= {{(IN_TDATA_W - IN_CNT_LSB - FIELD_W){1'b0}},
                            nxt.count, nxt.value, nxt.pos};
                send_gap <= pick_gap(send_calm);
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // result side stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_gap > 0) begin
                m_tready <= 0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1;
                recv_gap <= pick_gap(recv_calm);
            end
        end
    end

    // monitor: results are checked before the item of the same edge is predicted
    always @(posedge aclk) begin : monitor_proc
        list_result_t want;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: tdata %h tuser %b tlast %b",
                                 m_tdata, m_tuser, m_tlast);
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", VALUE_W'(want.ok), VALUE_W'(m_tdata[OUT_OK_LSB]));
                    check_field("removed", VALUE_W'(want.removed),
                                VALUE_W'(m_tdata[OUT_REM_LSB +: FIELD_W]));
                    check_field("has_element", VALUE_W'(want.has_el), VALUE_W'(m_tuser));
                    check_field("element", want.element, m_tdata[OUT_EL_LSB +: VALUE_W]);
                    check_field("is_last", VALUE_W'(want.last), VALUE_W'(m_tlast));
                    check_field("list_length", VALUE_W'(want.len),
                                VALUE_W'(m_tdata[OUT_LEN_LSB +: FIELD_W]));
                end
            end
            if (s_tvalid && s_tready)
                update_list(cur_cmd);
        end
    end

    initial begin
        #6000000;
        $display("timeout");
        $display("positional_list_insert_delete verification failed");
        $finish;
    end

    initial begin : main_proc
        int r, len_cap, total;
        // directed: empty list, bad positions, ends of the list, run edge cases
        add_cmd(OP_READ_OUT, 0, 0, 0);
        add_cmd(OP_DELETE, 1, 0, 0);
        add_cmd(OP_DELETE_RUN, 1, 0, 3);
        add_cmd(OP_DELETE_RUN, 0, 0, 0);
        add_cmd(OP_INSERT, 0, 32'h1234_5678, 0);
        add_cmd(OP_INSERT, 2, 32'h1234_5678, 0);
        add_cmd(OP_INSERT, 1, 32'h7fff_ffff, 0);
        add_cmd(OP_INSERT, 1, 32'h8000_0000, 0);
        add_cmd(OP_INSERT, 3, 32'hffff_ffff, 63);
        add_cmd(OP_INSERT, 2, 32'h5555_5555, 0);
        add_cmd(OP_INSERT, 63, 32'haaaa_aaaa, 0);
        add_cmd(OP_READ_OUT, 63, 32'hffff_ffff, 63);
        add_cmd(OP_DELETE, 5, 0, 0);
        add_cmd(OP_DELETE, 0, 0, 0);
        add_cmd(OP_DELETE, 4, 0, 0);
        add_cmd(OP_DELETE_RUN, 2, 0, 0);
        add_cmd(OP_DELETE_RUN, 1, 0, 63);
        add_cmd(OP_READ_OUT, 0, 0, 0);
        total = 18;

        // fill up to a full list, mostly valid inserts with some noise
        while (plan_len < DEPTH) begin
            r = $urandom_range(0, 7);
            if (r == 0)
                add_cmd(OP_INSERT, $urandom_range(0, 63), $urandom, $urandom_range(0, 63));
            else if (r == 1 && plan_len > 0)
                add_cmd(OP_DELETE_RUN, $urandom_range(1, plan_len), $urandom, 0);
            else
                add_cmd(OP_INSERT, $urandom_range(1, plan_len + 1), $urandom,
                        $urandom_range(0, 63));
            total++;
        end
        add_cmd(OP_INSERT, 1, $urandom, 0);
        add_cmd(OP_INSERT, DEPTH, $urandom, 0);
        add_cmd(OP_READ_OUT, 0, 0, 0, 1);
        add_cmd(OP_DELETE, DEPTH, 0, 0);
        add_cmd(OP_INSERT, DEPTH, $urandom, 0);
        total += 5;

        // mixed traffic, length kept moderate so read-outs stay short on average
        while (total < 132) begin
            r = $urandom_range(0, 99);
            len_cap = (plan_len > 0) ? plan_len : 1;
            if (r < 10)
                add_cmd(pli_op_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom,
                        $urandom_range(0, 63));
            else if (r < 45 && plan_len < 20)
                add_cmd(OP_INSERT, $urandom_range(1, plan_len + 1), $urandom, 0);
            else if (r < 70)
                add_cmd(OP_DELETE, $urandom_range(1, len_cap), $urandom, 0);
            else if (r < 85)
                add_cmd(OP_DELETE_RUN, $urandom_range(1, len_cap), $urandom,
                        ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 4));
            else if (r < 93)
                add_cmd(OP_READ_OUT, $urandom_range(0, 63), $urandom, $urandom_range(0, 63),
                        $urandom_range(0, 9) == 0);
            else
                add_cmd(OP_INSERT, $urandom_range(1, plan_len + 1), $urandom, 0);
            total++;
        end
        add_cmd(OP_READ_OUT, 0, 0, 0);

        repeat (9) @(negedge aclk);
        aresetn = 1;

        while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (64) @(negedge aclk);
        if (expected_results.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("ran %0d inserts, %0d deletes, %0d delete runs, %0d read-outs",
                 n_ins, n_del, n_run, n_rd);
        $display("checked %0d result items, list length peaked at %0d of %0d",
                 results_seen, peak_len, DEPTH);
        if (mismatches == 0)
            $display("positional_list_insert_delete verification clean");
        else
            $display("positional_list_insert_delete verification failed");
        $finish;
    end

endmodule
